// ----- hw/rtl/xrbg_pkg.sv -----
`timescale 1ns / 1ps
// Package for the xorshift128 random buffer generator.
// Holds beat types, generator control struct, seed resets and the character map.
package xrbg_pkg;

  localparam int unsigned DefMaxLength = 64;
  localparam int unsigned WordW        = 32;
  localparam int unsigned CntW         = 3;
  localparam int unsigned AddrW        = 4;

  localparam logic [WordW-1:0] SeedAReset = 32'd123456789;
  localparam logic [WordW-1:0] SeedBReset = 32'd362436069;
  localparam logic [WordW-1:0] SeedCReset = 32'd521288629;
  localparam logic [WordW-1:0] SeedDReset = 32'd88675123;

  localparam logic [1:0] RegSeedA = 2'd0;
  localparam logic [1:0] RegSeedB = 2'd1;
  localparam logic [1:0] RegSeedC = 2'd2;
  localparam logic [1:0] RegSeedD = 2'd3;

  localparam logic [CntW-1:0] CntOne  = 3'd1;
  localparam logic [CntW-1:0] CntTwo  = 3'd2;
  localparam logic [CntW-1:0] CntFour = 3'd4;

  localparam logic [255:0] CharTable = "abcdefghijklmnopqrstuvw012345678";

  typedef struct packed {
    logic       func;
    logic [6:0] length;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] data;
    logic [CntW-1:0]  byte_count;
    logic             last;
  } out_t;

  typedef struct packed {
    logic             load;
    logic [1:0]       sel;
    logic [WordW-1:0] value;
    logic             step;
  } gen_ctrl_t;

  function automatic logic [7:0] char_of(input logic [4:0] idx);
    char_of = CharTable[8*(31 - int'(idx)) +: 8];
  endfunction

  function automatic logic [WordW-1:0] map_word(input logic [WordW-1:0] v);
    logic [WordW-1:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      r[8*k +: 8] = char_of(v[8*k+3 +: 5]);
    end
    map_word = r;
  endfunction

endpackage

// ----- hw/rtl/xorshift_random_buffer_generator_unit.sv -----
`timescale 1ns / 1ps
// Random buffer generator top: request sequencer, chunk formatter, APB seed registers.
// First beat: a taken request loads state_q and rem_q, and the first chunk beat is then
// registered into out_q and out_valid_q.
// Throughput: one chunk per cycle while the output is not stalled; in_stall_o stays
// high from the taken request until the last beat is taken (one generator step per
// chunk plus the drain of the last beat), so a new request waits for that drain.
// Reset: generator words and seeds return to their reset values; no request pending.
module xorshift_random_buffer_generator_unit #(
  parameter int unsigned MAX_LENGTH = xrbg_pkg::DefMaxLength
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  xrbg_pkg::in_t                 in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output xrbg_pkg::out_t                out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [xrbg_pkg::AddrW-1:0]    paddr,
  input  logic [xrbg_pkg::WordW-1:0]    pwdata,
  output logic [xrbg_pkg::WordW-1:0]    prdata,
  output logic                          pready
);
  import xrbg_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_LENGTH + 1);
  localparam int unsigned CmpW = (LenW > 7) ? LenW : 7;

  typedef enum logic {
    StIdle,
    StBusy
  } state_e;

  state_e           state_q;
  logic [LenW-1:0]  rem_q;
  logic             alpha_q;
  logic             out_valid_q;
  out_t             out_q;

  logic [WordW-1:0] seed_a_q, seed_b_q, seed_c_q, seed_d_q;
  logic             cfg_wr;
  logic [1:0]       cfg_sel;

  logic             in_acc;
  logic [CmpW-1:0]  req_len;
  logic [LenW-1:0]  sat_len;
  logic             slot_free;
  logic             do_gen;
  logic [WordW-1:0] step_val;
  out_t             chunk;
  gen_ctrl_t        gen_ctrl;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_sel)
      RegSeedA: prdata = seed_a_q;
      RegSeedB: prdata = seed_b_q;
      RegSeedC: prdata = seed_c_q;
      RegSeedD: prdata = seed_d_q;
      default:  prdata = '0;
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign req_len     = CmpW'(in_i.length);
  assign sat_len     = (req_len > CmpW'(MAX_LENGTH)) ? LenW'(MAX_LENGTH) : LenW'(req_len);

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign do_gen      = (state_q == StBusy) && slot_free && !(out_valid_q && out_q.last);

  assign gen_ctrl.load  = cfg_wr;
  assign gen_ctrl.sel   = cfg_sel;
  assign gen_ctrl.value = pwdata;
  assign gen_ctrl.step  = do_gen;

  xrbg_gen u_gen (
    .clk_i,
    .rst_ni,
    .ctrl_i     (gen_ctrl),
    .step_val_o (step_val)
  );

  always_comb begin
    chunk = '0;
    if (rem_q >= LenW'(4)) begin
      chunk.data       = alpha_q ? map_word(step_val) : step_val;
      chunk.byte_count = CntFour;
    end else if (alpha_q) begin
      chunk.data       = {24'd0, char_of(step_val[4:0])};
      chunk.byte_count = CntOne;
    end else if (rem_q >= LenW'(2)) begin
      chunk.data       = {16'd0, step_val[15:0]};
      chunk.byte_count = CntTwo;
    end else begin
      chunk.data       = {24'd0, step_val[7:0]};
      chunk.byte_count = CntOne;
    end
    chunk.last = (rem_q == LenW'(chunk.byte_count));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_a_q <= SeedAReset;
      seed_b_q <= SeedBReset;
      seed_c_q <= SeedCReset;
      seed_d_q <= SeedDReset;
    end else if (cfg_wr) begin
      case (cfg_sel)
        RegSeedA: seed_a_q <= pwdata;
        RegSeedB: seed_b_q <= pwdata;
        RegSeedC: seed_c_q <= pwdata;
        RegSeedD: seed_d_q <= pwdata;
        default:  seed_a_q <= seed_a_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      alpha_q     <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_acc && (sat_len != '0)) begin
            rem_q   <= sat_len;
            alpha_q <= in_i.func;
            state_q <= StBusy;
          end
        end
        StBusy: begin
          if (do_gen) begin
            out_valid_q <= 1'b1;
            rem_q       <= rem_q - LenW'(chunk.byte_count);
          end else if (out_valid_q && out_q.last && !out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_gen) begin
      out_q <= chunk;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- hw/rtl/xrbg_gen.sv -----
`timescale 1ns / 1ps
// Xorshift128 generator: four state words and the shared step unit.
// Depends on xrbg_pkg for the control struct and seed resets.
module xrbg_gen (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  xrbg_pkg::gen_ctrl_t        ctrl_i,
  output logic [xrbg_pkg::WordW-1:0] step_val_o
);
  import xrbg_pkg::*;

  logic [WordW-1:0] word_a_q, word_b_q, word_c_q, word_d_q;
  logic [WordW-1:0] t_shl, t_val;

  assign t_shl      = word_a_q ^ (word_a_q << 11);
  assign t_val      = t_shl ^ (t_shl >> 8);
  assign step_val_o = word_d_q ^ (word_d_q >> 19) ^ t_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_a_q <= SeedAReset;
      word_b_q <= SeedBReset;
      word_c_q <= SeedCReset;
      word_d_q <= SeedDReset;
    end else if (ctrl_i.load) begin
      case (ctrl_i.sel)
        RegSeedA: word_a_q <= ctrl_i.value;
        RegSeedB: word_b_q <= ctrl_i.value;
        RegSeedC: word_c_q <= ctrl_i.value;
        RegSeedD: word_d_q <= ctrl_i.value;
        default:  word_a_q <= word_a_q;
      endcase
    end else if (ctrl_i.step) begin
      word_a_q <= word_b_q;
      word_b_q <= word_c_q;
      word_c_q <= word_d_q;
      word_d_q <= step_val_o;
    end
  end

endmodule

// ----- hw/rtl/xrbg_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the random buffer generator, bound to the top level.
// Depends on xrbg_pkg for the beat types.
module xrbg_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input xrbg_pkg::in_t  in_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input xrbg_pkg::out_t out_o
);
  import xrbg_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled output beat changed");

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while chunk beat pending");

  a_req_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_i.length != 7'd0) |-> ##2 out_valid_o)
    else $error("first chunk beat late");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.byte_count == CntOne) || (out_o.byte_count == CntTwo) ||
                    (out_o.byte_count == CntFour))
    else $error("bad byte count");

endmodule

bind xorshift_random_buffer_generator_unit xrbg_checker u_xrbg_checker (
  .clk_i,
  .rst_ni,
  .in_valid_i,
  .in_stall_o,
  .in_i,
  .out_valid_o,
  .out_stall_i,
  .out_o
);

// ----- test/xorshift_random_buffer_generator_unit_test.sv -----
`timescale 1ns / 1ps
// Testbench for xorshift_random_buffer_generator_unit: directed table, then random requests.
// Holds its own xorshift128 chunk predictor and an APB seed driver; needs xrbg_pkg.
module xorshift_random_buffer_generator_unit_test;
  import xrbg_pkg::*;

  localparam logic FuncRaw   = 1'b0;
  localparam logic FuncAlpha = 1'b1;

  localparam int MaxRequest   = DefMaxLength;
  localparam int SettleCycles = 10;
  localparam int CycleLimit   = 400000;
  localparam int RandomPhases = 5;
  localparam int PhaseItems   = 48;

  localparam logic [255:0] Alphabet = "abcdefghijklmnopqrstuvw012345678";

  typedef enum logic {ROW_REQ, ROW_SEED} row_kind_e;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_mode_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  sel;
    logic        func;
    logic [6:0]  length;
    logic        fixed;
    logic [31:0] value;
  } row_t;

  localparam int DirectedRows = 29;
  localparam row_t Directed [DirectedRows] = '{
    '{ROW_REQ,  RegSeedA, FuncRaw,   7'd1,   1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncRaw,   7'd2,   1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncRaw,   7'd3,   1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncRaw,   7'd4,   1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncRaw,   7'd5,   1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncRaw,   7'd7,   1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncRaw,   7'd64,  1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncRaw,   7'd65,  1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncRaw,   7'd127, 1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncRaw,   7'd0,   1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncAlpha, 7'd1,   1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncAlpha, 7'd3,   1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncAlpha, 7'd4,   1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncAlpha, 7'd6,   1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncAlpha, 7'd64,  1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncAlpha, 7'd127, 1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncAlpha, 7'd0,   1'b0, 32'd0},
    '{ROW_SEED, RegSeedA, FuncRaw,   7'd0,   1'b0, 32'd0},
    '{ROW_SEED, RegSeedB, FuncRaw,   7'd0,   1'b0, 32'd0},
    '{ROW_SEED, RegSeedC, FuncRaw,   7'd0,   1'b0, 32'd0},
    '{ROW_SEED, RegSeedD, FuncRaw,   7'd0,   1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncRaw,   7'd7,   1'b1, 32'h0000_0000},
    '{ROW_REQ,  RegSeedA, FuncAlpha, 7'd9,   1'b1, 32'h6161_6161},
    '{ROW_SEED, RegSeedA, FuncRaw,   7'd0,   1'b0, 32'hFFFF_FFFF},
    '{ROW_SEED, RegSeedB, FuncRaw,   7'd0,   1'b0, 32'hFFFF_FFFF},
    '{ROW_SEED, RegSeedC, FuncRaw,   7'd0,   1'b0, 32'hFFFF_FFFF},
    '{ROW_SEED, RegSeedD, FuncRaw,   7'd0,   1'b0, 32'hFFFF_FFFF},
    '{ROW_REQ,  RegSeedA, FuncRaw,   7'd64,  1'b0, 32'd0},
    '{ROW_REQ,  RegSeedA, FuncAlpha, 7'd63,  1'b0, 32'd0}
  };

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_t                in_i        = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_t               out_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [AddrW-1:0]   paddr       = '0;
  logic [WordW-1:0]   pwdata      = '0;
  logic [WordW-1:0]   prdata;
  logic               pready;

  logic [31:0]  xs_word [4];
  out_t         pending_chunks [$];
  int           chunk_faults    = 0;
  int           readback_faults = 0;
  int           chunks_seen     = 0;
  int           requests_taken  = 0;
  int           seed_writes     = 0;
  int           cycle_count     = 0;
  stall_mode_e  stall_mode      = STALL_NONE;
  int           stall_hold      = 0;
  int           stall_tick      = 0;

  xorshift_random_buffer_generator_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [31:0] advance_xorshift();
    logic [31:0] t;
    t = xs_word[0];
    t = t ^ (t << 11);
    t = t ^ (t >> 8);
    xs_word[0] = xs_word[1];
    xs_word[1] = xs_word[2];
    xs_word[2] = xs_word[3];
    xs_word[3] = xs_word[3] ^ (xs_word[3] >> 19) ^ t;
    return xs_word[3];
  endfunction

  function automatic logic [7:0] glyph(input logic [4:0] idx);
    return Alphabet[255 - 8 * int'(idx) -: 8];
  endfunction

  function automatic void predict_chunks(input in_t req, input logic fixed,
                                         input logic [31:0] fixed_word);
    int          remaining;
    logic [31:0] v;
    out_t        c;
    remaining = (int'(req.length) > MaxRequest) ? MaxRequest : int'(req.length);
    while (remaining > 0) begin
      v = advance_xorshift();
      if (remaining >= 4) begin
        c.byte_count = CntFour;
        c.data = v;
        if (req.func == FuncAlpha) begin
          for (int k = 0; k < 4; k++) c.data[8*k +: 8] = glyph(v[8*k+3 +: 5]);
        end
      end else if (req.func == FuncAlpha) begin
        c.byte_count = CntOne;
        c.data = {24'd0, glyph(v[4:0])};
      end else if (remaining >= 2) begin
        c.byte_count = CntTwo;
        c.data = {16'd0, v[15:0]};
      end else begin
        c.byte_count = CntOne;
        c.data = {24'd0, v[7:0]};
      end
      remaining -= int'(c.byte_count);
      c.last = (remaining == 0);
      if (fixed) begin
        c.data = fixed_word & ((c.byte_count == CntFour) ? 32'hFFFF_FFFF :
                               (c.byte_count == CntTwo) ? 32'h0000_FFFF : 32'h0000_00FF);
      end
      pending_chunks.push_back(c);
    end
  endfunction

  function automatic in_t random_request();
    in_t r;
    int  pick;
    pick = $urandom_range(0, 99);
    r.func = 1'($urandom_range(0, 1));
    if (pick < 4) r.length = 7'd0;
    else if (pick < 9) r.length = 7'($urandom_range(65, 127));
    else if (pick < 22) r.length = 7'($urandom_range(17, 64));
    else r.length = 7'($urandom_range(1, 16));
    return r;
  endfunction

  function automatic logic [31:0] random_seed();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 32'h0000_0000;
    if (pick == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_request(input in_t req, input logic fixed, input logic [31:0] fixed_word);
    @(negedge clk_i);
    in_i       <= req;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_chunks(req, fixed, fixed_word);
    requests_taken++;
  endtask

  task automatic idle_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      in_i       <= in_t'(8'($urandom));
    end
  endtask

  task automatic wait_quiet();
    idle_input(1);
    while (pending_chunks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [1:0] sel, output logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    value = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_seed(input logic [1:0] sel, input logic [31:0] want);
    logic [31:0] got;
    apb_read(sel, got);
    if (got !== want) begin
      readback_faults++;
      $display("%0t: seed %0d readback expected %h actual %h", $time, sel, want, got);
    end
  endtask

  task automatic write_seed(input logic [1:0] sel, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    xs_word[sel] = value;
    seed_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_seed(sel, value);
  endtask

  always @(negedge clk_i) begin
    if (stall_hold == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_hold <= $urandom_range(20, 90);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    stall_tick <= (stall_tick == 4) ? 0 : stall_tick + 1;
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= (stall_tick < 3);
    endcase
  end

  always @(posedge clk_i) begin : check_chunk
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chunks_seen++;
      if (pending_chunks.size() == 0) begin
        chunk_faults++;
        $display("%0t: unexpected beat expected none actual data %h count %0d last %0b",
                 $time, out_o.data, out_o.byte_count, out_o.last);
      end else begin
        want = pending_chunks.pop_front();
        if (out_o.data !== want.data) begin
          chunk_faults++;
          $display("%0t: data expected %h actual %h", $time, want.data, out_o.data);
        end
        if (out_o.byte_count !== want.byte_count) begin
          chunk_faults++;
          $display("%0t: byte_count expected %0d actual %0d", $time, want.byte_count,
                   out_o.byte_count);
        end
        if (out_o.last !== want.last) begin
          chunk_faults++;
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_o.last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d beats outstanding", $time, pending_chunks.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    row_t  row;
    in_t   req;
    int    sent;
    int    burst;
    xs_word[0] = SeedAReset;
    xs_word[1] = SeedBReset;
    xs_word[2] = SeedCReset;
    xs_word[3] = SeedDReset;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    check_seed(RegSeedA, SeedAReset);
    check_seed(RegSeedB, SeedBReset);
    check_seed(RegSeedC, SeedCReset);
    check_seed(RegSeedD, SeedDReset);

    for (int i = 0; i < DirectedRows; i++) begin
      row = Directed[i];
      if (row.kind == ROW_SEED) begin
        wait_quiet();
        write_seed(row.sel, row.value);
      end else begin
        req.func   = row.func;
        req.length = row.length;
        send_request(req, row.fixed, row.value);
        idle_input($urandom_range(0, 2));
      end
    end

    for (int phase = 0; phase < RandomPhases; phase++) begin
      wait_quiet();
      write_seed(RegSeedA, random_seed());
      write_seed(RegSeedB, random_seed());
      write_seed(RegSeedC, random_seed());
      write_seed(RegSeedD, random_seed());
      sent = 0;
      while (sent < PhaseItems) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          if (sent < PhaseItems) begin
            send_request(random_request(), 1'b0, 32'd0);
            sent++;
          end
        end
        idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end
    end

    wait_quiet();
    $display("Ran %0d requests in raw and alphanumeric modes, %0d beats checked,",
             requests_taken, chunks_seen);
    $display("%0d seed writes with readback, zero and all-ones seeds included.", seed_writes);
    if (chunk_faults == 0 && readback_faults == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/xrbg_pkg.sv
hw/rtl/xrbg_gen.sv
hw/rtl/xorshift_random_buffer_generator_unit.sv
hw/rtl/xrbg_checker.sv
test/xorshift_random_buffer_generator_unit_test.sv
